[src/tpr_pkg.sv]
// ----------------------------------------------------------------------------
// tpr_pkg
// shared types, constants and reset values of the telemetry poll responder
// ----------------------------------------------------------------------------
package tpr_pkg;

  // received frame length limit, count saturates here
  localparam int RX_FRAME_BYTES = 16;
  localparam int RX_COUNT_W     = $clog2(RX_FRAME_BYTES + 1);

  // answer length before stuffing
  localparam int FRAME_BYTES = 8;
  localparam int BYTE_IDX_W  = $clog2(FRAME_BYTES);

  // job queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCOUNT_W    = $clog2(QUEUE_DEPTH + 1);

  // line codes
  localparam logic [7:0] START_BYTE   = 8'h7E;
  localparam logic [7:0] ESC_BYTE     = 8'h7D;
  localparam logic [7:0] ESC_START    = 8'h5E;
  localparam logic [7:0] ESC_ESC      = 8'h5D;
  localparam logic [7:0] STUFF_MASK   = 8'h5F;

  // request kinds
  localparam logic REQ_LINE_BYTE = 1'b0;
  localparam logic REQ_LOAD      = 1'b1;

  // configuration register map
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_MY_ID         = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEND_INTERVAL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_TYPE    = 2'd2;

  localparam logic [7:0]  MY_ID_RESET         = 8'd106;
  localparam logic [15:0] SEND_INTERVAL_RESET = 16'd0;
  localparam logic [7:0]  FRAME_TYPE_RESET    = 8'd16;

  typedef struct packed {
    logic        req_type;
    logic [7:0]  rx_byte;
    logic [31:0] now_ms;
    logic [15:0] sensor_id;
    logic [31:0] sensor_value;
  } in_item_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       valid_frame;
    logic       last;
  } out_item_t;

  // one answer, bytes before stuffing, byte 0 sent first
  typedef struct packed {
    logic                              valid_frame;
    logic [FRAME_BYTES-1:0][7:0]       bytes;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_BYTE,
    BK_STUFF
  } back_state_t;

  function automatic logic needs_stuff(input logic [7:0] b);
    return (b == START_BYTE) || (b == ESC_BYTE);
  endfunction

endpackage

[src/tpr_front.sv]
// ----------------------------------------------------------------------------
// tpr_front
// accepts items, decodes line bytes, stages sensor data and builds answers
// ----------------------------------------------------------------------------
module tpr_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  tpr_pkg::in_item_t             in_item,
  input  logic                          cfg_we,
  input  logic [tpr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tpr_pkg::CFG_DATA_W-1:0] cfg_data,
  input  tpr_pkg::q_status_t            q_status,
  output logic                          q_push,
  output tpr_pkg::job_t                 q_job
);
  import tpr_pkg::*;

  logic [7:0]            my_id;
  logic [15:0]           send_interval_ms;
  logic [7:0]            frame_type;
  logic [RX_COUNT_W-1:0] rx_count;
  logic [RX_COUNT_W-1:0] rx_count_next;
  logic                  escape_pending;
  logic                  escape_pending_next;
  logic                  data_ready;
  logic [31:0]           last_send_time;
  logic [15:0]           staged_id;
  logic [31:0]           staged_value;

  logic                  accept;
  logic                  is_line;
  logic                  is_load;
  logic                  counted;
  logic [7:0]            dec_byte;
  logic                  poll;
  logic [31:0]           elapsed;
  logic                  ans_valid;
  logic [10:0]           sum;
  logic [15:0]           neg_sum;
  logic [7:0]            checksum;

  assign in_stall = q_status.full;
  assign accept   = in_valid && !in_stall;
  assign is_load  = in_item.req_type == REQ_LOAD;
  assign is_line  = in_item.req_type == REQ_LINE_BYTE;

  // byte decode and frame counting
  always_comb begin
    dec_byte            = in_item.rx_byte;
    counted             = 1'b0;
    escape_pending_next = escape_pending;
    rx_count_next       = rx_count;
    if (in_item.rx_byte == START_BYTE) begin
      rx_count_next       = '0;
      escape_pending_next = 1'b0;
    end else if (in_item.rx_byte == ESC_BYTE) begin
      escape_pending_next = 1'b1;
    end else begin
      counted             = 1'b1;
      escape_pending_next = 1'b0;
      if (escape_pending && in_item.rx_byte == ESC_START) begin
        dec_byte = START_BYTE;
      end else if (escape_pending && in_item.rx_byte == ESC_ESC) begin
        dec_byte = ESC_BYTE;
      end
      if (rx_count < RX_COUNT_W'(RX_FRAME_BYTES)) begin
        rx_count_next = rx_count + 1'b1;
      end
    end
    // first counted byte matching our id answers at once, count restarts
    poll = counted && (rx_count == '0) && (dec_byte == my_id);
    if (poll) begin
      rx_count_next = '0;
    end
  end

  // answer content
  assign elapsed   = in_item.now_ms - last_send_time;
  assign ans_valid = data_ready && (elapsed >= {16'd0, send_interval_ms});

  assign sum = 11'(frame_type) + 11'(staged_id[7:0]) + 11'(staged_id[15:8])
             + 11'(staged_value[7:0]) + 11'(staged_value[15:8])
             + 11'(staged_value[23:16]) + 11'(staged_value[31:24]);
  assign neg_sum  = 16'd0 - 16'(sum);
  assign checksum = neg_sum[7:0] + neg_sum[15:8];

  always_comb begin
    q_job.valid_frame = ans_valid;
    q_job.bytes       = '0;
    if (ans_valid) begin
      q_job.bytes[0] = frame_type;
      q_job.bytes[1] = staged_id[7:0];
      q_job.bytes[2] = staged_id[15:8];
      q_job.bytes[3] = staged_value[7:0];
      q_job.bytes[4] = staged_value[15:8];
      q_job.bytes[5] = staged_value[23:16];
      q_job.bytes[6] = staged_value[31:24];
      q_job.bytes[7] = checksum;
    end
  end

  assign q_push = accept && is_line && poll;

  always_ff @(posedge clk) begin
    if (rst) begin
      my_id            <= MY_ID_RESET;
      send_interval_ms <= SEND_INTERVAL_RESET;
      frame_type       <= FRAME_TYPE_RESET;
      rx_count         <= '0;
      escape_pending   <= 1'b0;
      data_ready       <= 1'b0;
      last_send_time   <= '0;
      staged_id        <= '0;
      staged_value     <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_MY_ID:         my_id            <= cfg_data[7:0];
          CFG_SEND_INTERVAL: send_interval_ms <= cfg_data;
          CFG_FRAME_TYPE:    frame_type       <= cfg_data[7:0];
          default: ;
        endcase
      end
      if (accept && is_load) begin
        staged_id    <= in_item.sensor_id;
        staged_value <= in_item.sensor_value;
        data_ready   <= 1'b1;
      end
      if (accept && is_line) begin
        rx_count       <= rx_count_next;
        escape_pending <= escape_pending_next;
        if (poll && ans_valid) begin
          last_send_time <= in_item.now_ms;
          data_ready     <= 1'b0;
        end
      end
    end
  end

  // an empty answer keeps staged data
  a_empty_keeps_data: assert property (@(posedge clk) disable iff (rst)
    (accept && is_line && poll && !ans_valid) |=> data_ready == $past(data_ready))
    else $error("empty answer changed data_ready");

  // a data frame consumes staged data and stamps the send time
  a_frame_stamps_time: assert property (@(posedge clk) disable iff (rst)
    (accept && is_line && poll && ans_valid)
      |=> (!data_ready && last_send_time == $past(in_item.now_ms)))
    else $error("data frame did not update send time");

  // no push into a full queue
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_status.full)
    else $error("push into full queue");

endmodule

[src/tpr_queue.sv]
// ----------------------------------------------------------------------------
// tpr_queue
// short answer queue between front and back
// ----------------------------------------------------------------------------
module tpr_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  tpr_pkg::job_t      push_job,
  input  logic               pop,
  output tpr_pkg::job_t      head_job,
  output tpr_pkg::q_status_t status
);
  import tpr_pkg::*;

  job_t                entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCOUNT_W-1:0] count;

  assign status.full  = count == QCOUNT_W'(QUEUE_DEPTH);
  assign status.empty = count == '0;
  assign head_job     = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !status.empty)
    else $error("pop from empty queue");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCOUNT_W'(QUEUE_DEPTH))
    else $error("queue count overflow");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + 1'b1)
    else $error("queue count did not grow on push");

endmodule

[src/tpr_back.sv]
// ----------------------------------------------------------------------------
// tpr_back
// serializes queued answers with escape stuffing into an output register
// ----------------------------------------------------------------------------
module tpr_back (
  input  logic                clk,
  input  logic                rst,
  input  tpr_pkg::q_status_t  q_status,
  input  tpr_pkg::job_t       q_head,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output tpr_pkg::out_item_t  out_item
);
  import tpr_pkg::*;

  back_state_t           state;
  back_state_t           state_next;
  job_t                  job;
  logic [BYTE_IDX_W-1:0] idx;
  logic [7:0]            cur;
  logic                  cur_special;
  logic                  out_load;
  logic                  byte_done;
  logic [7:0]            emit_byte;
  logic                  emit_last;

  assign cur         = job.bytes[idx];
  assign cur_special = needs_stuff(cur);
  assign out_load    = (state != BK_IDLE) && (!out_valid || !out_stall);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (!q_status.empty) state_next = BK_BYTE;
      end
      BK_BYTE: begin
        if (out_load) begin
          if (cur_special) state_next = BK_STUFF;
          else if (idx == BYTE_IDX_W'(FRAME_BYTES - 1)) state_next = BK_IDLE;
        end
      end
      BK_STUFF: begin
        if (out_load) begin
          state_next = (idx == BYTE_IDX_W'(FRAME_BYTES - 1)) ? BK_IDLE : BK_BYTE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    q_pop     = 1'b0;
    emit_byte = cur;
    byte_done = 1'b0;
    unique case (state)
      BK_IDLE: begin
        q_pop = !q_status.empty;
      end
      BK_BYTE: begin
        emit_byte = cur_special ? ESC_BYTE : cur;
        byte_done = !cur_special;
      end
      BK_STUFF: begin
        emit_byte = cur & STUFF_MASK;
        byte_done = 1'b1;
      end
      default: ;
    endcase
    emit_last = byte_done && (idx == BYTE_IDX_W'(FRAME_BYTES - 1));
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      job <= q_head;
    end
    if (out_load) begin
      out_item.tx_byte     <= emit_byte;
      out_item.valid_frame <= job.valid_frame;
      out_item.last        <= emit_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (q_pop) begin
        idx <= '0;
      end else if (out_load && byte_done) begin
        idx <= idx + 1'b1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // second half of a stuffed pair always follows an escape byte in the register
  a_stuff_after_esc: assert property (@(posedge clk) disable iff (rst)
    state == BK_STUFF |-> (out_valid && out_item.tx_byte == ESC_BYTE))
    else $error("stuff phase without escape byte in output");

  // the final byte of an answer returns the serializer to idle
  a_last_to_idle: assert property (@(posedge clk) disable iff (rst)
    (out_load && emit_last) |=> state == BK_IDLE)
    else $error("serializer kept running after last byte");

  // a new answer is fetched only when idle
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> (state == BK_BYTE && idx == '0))
    else $error("fetch did not start a new answer");

endmodule

[src/telemetry_poll_responder_core.sv]
// ----------------------------------------------------------------------------
// telemetry_poll_responder_core
// poll-answering slave for a half-duplex telemetry line
// ----------------------------------------------------------------------------
// usage:
//   input channel (in_valid / in_stall / in_item) carries either a received
//   line byte or a sensor-load beat. the front accepts one beat per cycle and
//   only stalls while the two-entry answer queue is full.
//   a line byte equal to my_id as first byte of a frame is a poll; the front
//   builds the 8-byte answer (data frame or all zeros) at once and queues it.
//   output channel (out_valid / out_stall / out_item) gives one stuffed byte
//   per beat, 8 to 16 beats per answer, last set on the final beat.
//   the first answer byte reaches the output through a fetch (the idle state
//   pops the queue) and then an output register load.
//   throughput: one output byte per cycle while not stalled, plus a fetch in
//   the idle state between answers; the serializer byte loop sets the answer rate.
//   a stall on the output holds the output register; the queue keeps taking
//   polls until full, so the input side runs on independently.
//   reset (rst, synchronous) clears decode state, staged data, the queue and
//   out_valid (not the output data), and restores the configuration defaults.
//   configuration writes (cfg_we / cfg_index / cfg_data) take effect the
//   next cycle and are meant for an idle block.
// ----------------------------------------------------------------------------
module telemetry_poll_responder_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  tpr_pkg::in_item_t              in_item,
  output logic                           out_valid,
  input  logic                           out_stall,
  output tpr_pkg::out_item_t             out_item,
  input  logic                           cfg_we,
  input  logic [tpr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tpr_pkg::CFG_DATA_W-1:0] cfg_data
);
  import tpr_pkg::*;

  q_status_t q_status;
  logic      q_push;
  logic      q_pop;
  job_t      push_job;
  job_t      head_job;

  // front: decode, stage, decide and build answers
  tpr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_status  (q_status),
    .q_push    (q_push),
    .q_job     (push_job)
  );

  // answer queue decoupling the two sides
  tpr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (push_job),
    .pop      (q_pop),
    .head_job (head_job),
    .status   (q_status)
  );

  // back: stuffing serializer with output register
  tpr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_status  (q_status),
    .q_head    (head_job),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule
